>>> src/rgbe_scan_pkg.sv
package rgbe_scan_pkg;

   typedef struct packed {
      logic        start_flag;
      logic [7:0]  byte_value;
      logic [31:0] span_limit;
   } item_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] total_length;
      logic [14:0] image_height;
      logic [14:0] image_width;
   } result_type;

   localparam logic [2:0] VERDICT_OK        = 3'd0;
   localparam logic [2:0] VERDICT_NO_DIMS   = 3'd1;
   localparam logic [2:0] VERDICT_DIM_RANGE = 3'd2;
   localparam logic [2:0] VERDICT_MARKER    = 3'd3;
   localparam logic [2:0] VERDICT_BAD_RUN   = 3'd4;
   localparam logic [2:0] VERDICT_TRUNC     = 3'd5;

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_FIND_Y = 4'd1;
   localparam logic [3:0] PH_HEIGHT = 4'd2;
   localparam logic [3:0] PH_FIND_X = 4'd3;
   localparam logic [3:0] PH_WIDTH  = 4'd4;
   localparam logic [3:0] PH_NL     = 4'd5;
   localparam logic [3:0] PH_M0     = 4'd6;
   localparam logic [3:0] PH_M1     = 4'd7;
   localparam logic [3:0] PH_WHI    = 4'd8;
   localparam logic [3:0] PH_WLO    = 4'd9;
   localparam logic [3:0] PH_CODE   = 4'd10;
   localparam logic [3:0] PH_RUNVAL = 4'd11;
   localparam logic [3:0] PH_LIT    = 4'd12;

   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_Y       = 8'h59;
   localparam logic [7:0] CH_X       = 8'h58;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] SCAN_MARK  = 8'h02;
   localparam logic [7:0] RUN_FLOOR  = 8'd128;
   localparam logic [31:0] MIN_SPAN  = 32'd32;

   // "-Y " or "+X ", one char per index
   function automatic logic [7:0] tok_char(input logic use_x, input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = use_x ? CH_PLUS : CH_MINUS;
         2'd1:    c = use_x ? CH_X : CH_Y;
         default: c = CH_SPACE;
      endcase
      return c;
   endfunction

   // returns {hit, next match count}
   function automatic logic [2:0] tok_step(input logic [7:0] b, input logic [1:0] m,
                                           input logic use_x);
      logic [1:0] mn;
      if (b == tok_char(use_x, m)) begin
         mn = m + 2'd1;
      end else if (b == tok_char(use_x, 2'd0)) begin
         mn = 2'd1;
      end else begin
         mn = 2'd0;
      end
      return (mn == 2'd3) ? 3'b100 : {1'b0, mn};
   endfunction

endpackage

>>> src/rgbe_scan_core.sv
module rgbe_scan_core #(
   parameter int HEADER_WINDOW = 4096,
   parameter int MAX_DIM       = 16384
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  rgbe_scan_pkg::item_type  item,
   output logic                     result_fire,
   output rgbe_scan_pkg::result_type result
);
   import rgbe_scan_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [1:0]  tm_ff, tm_in;
   logic [14:0] acc_ff, acc_in;
   logic        over_ff, over_in;
   logic [14:0] hgt_ff, hgt_in;
   logic [14:0] wid_ff, wid_in;
   logic [14:0] row_ff, row_in;
   logic [1:0]  chi_ff, chi_in;
   logic [14:0] rem_ff, rem_in;
   logic [7:0]  skip_ff, skip_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] lim_ff, lim_in;

   logic [3:0]  c_phase;
   logic [1:0]  c_tm;
   logic [14:0] c_acc, c_hgt, c_wid, c_row, c_rem;
   logic        c_over;
   logic [1:0]  c_chi;
   logic [7:0]  c_skip;
   logic [31:0] c_off;

   logic        active, commit, fin, chunk, is_dig, run;
   logic [7:0]  b, n, skip_dec;
   logic [18:0] t;
   logic [14:0] acc_d, nval, nval_nx, row_inc;
   logic        over_d;
   logic [2:0]  tok;
   logic [2:0]  verdict;
   logic [31:0] len;
   logic [32:0] need, bound;

   always_comb begin
      b = item.byte_value;
      active = item.start_flag || (phase_ff != PH_IDLE);
      commit = step && active;

      if (item.start_flag) begin
         c_phase = PH_FIND_Y;
         c_tm    = '0;
         c_acc   = '0;
         c_over  = 1'b0;
         c_hgt   = '0;
         c_wid   = '0;
         c_row   = '0;
         c_chi   = '0;
         c_rem   = '0;
         c_skip  = '0;
         c_off   = '0;
         lim_in  = item.span_limit;
      end else begin
         c_phase = phase_ff;
         c_tm    = tm_ff;
         c_acc   = acc_ff;
         c_over  = over_ff;
         c_hgt   = hgt_ff;
         c_wid   = wid_ff;
         c_row   = row_ff;
         c_chi   = chi_ff;
         c_rem   = rem_ff;
         c_skip  = skip_ff;
         c_off   = off_ff;
         lim_in  = lim_ff;
      end

      phase_in = c_phase;
      tm_in    = c_tm;
      acc_in   = c_acc;
      over_in  = c_over;
      hgt_in   = c_hgt;
      wid_in   = c_wid;
      row_in   = c_row;
      chi_in   = c_chi;
      rem_in   = c_rem;
      skip_in  = c_skip;
      off_in   = c_off;

      fin     = 1'b0;
      chunk   = 1'b0;
      verdict = VERDICT_OK;
      len     = '0;
      need    = 33'd1;
      bound   = '0;
      nval_nx = '0;

      is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
      t = 19'(c_acc) * 19'd10 + 19'(b - CH_ZERO);
      if (c_over) begin
         acc_d  = c_acc;
         over_d = 1'b1;
      end else if (t > 19'(MAX_DIM)) begin
         acc_d  = c_acc;
         over_d = 1'b1;
      end else begin
         acc_d  = t[14:0];
         over_d = 1'b0;
      end
      nval = c_over ? '0 : c_acc;

      tok = tok_step(b, (c_phase == PH_HEIGHT) ? 2'd0 : c_tm, c_phase != PH_FIND_Y);
      run = b > RUN_FLOOR;
      n = run ? {1'b0, b[6:0]} : b;
      skip_dec = (c_skip != 8'd0) ? c_skip - 8'd1 : c_skip;
      row_inc = c_row + 15'd1;

      if (item.start_flag && (item.span_limit < MIN_SPAN)) begin
         fin     = 1'b1;
         verdict = VERDICT_TRUNC;
      end else begin
         case (c_phase)
            PH_FIND_Y, PH_FIND_X: begin
               tm_in = tok[1:0];
               if (tok[2]) begin
                  phase_in = (c_phase == PH_FIND_Y) ? PH_HEIGHT : PH_WIDTH;
                  acc_in   = '0;
                  over_in  = 1'b0;
               end
            end
            PH_HEIGHT: begin
               if (is_dig) begin
                  acc_in  = acc_d;
                  over_in = over_d;
               end else begin
                  hgt_in = nval;
                  tm_in  = tok[1:0];
                  if (tok[2]) begin
                     phase_in = PH_WIDTH;
                     acc_in   = '0;
                     over_in  = 1'b0;
                  end else begin
                     phase_in = PH_FIND_X;
                  end
               end
            end
            PH_WIDTH: begin
               if (is_dig) begin
                  acc_in  = acc_d;
                  over_in = over_d;
               end else begin
                  wid_in = nval;
                  if ((c_hgt == '0) || (nval == '0)) begin
                     fin     = 1'b1;
                     verdict = VERDICT_DIM_RANGE;
                  end else if (b == CH_NEWLINE) begin
                     row_in   = '0;
                     phase_in = PH_M0;
                  end else begin
                     phase_in = PH_NL;
                  end
               end
            end
            PH_NL: begin
               if (b == CH_NEWLINE) begin
                  row_in   = '0;
                  phase_in = PH_M0;
               end
            end
            PH_M0, PH_M1: begin
               if (b != SCAN_MARK) begin
                  fin     = 1'b1;
                  verdict = VERDICT_MARKER;
               end else begin
                  phase_in = (c_phase == PH_M0) ? PH_M1 : PH_WHI;
               end
            end
            PH_WHI: begin
               if (b != {1'b0, c_wid[14:8]}) begin
                  fin     = 1'b1;
                  verdict = VERDICT_MARKER;
               end else begin
                  phase_in = PH_WLO;
               end
            end
            PH_WLO: begin
               if (b != c_wid[7:0]) begin
                  fin     = 1'b1;
                  verdict = VERDICT_MARKER;
               end else begin
                  chi_in   = '0;
                  rem_in   = c_wid;
                  phase_in = PH_CODE;
               end
            end
            PH_CODE: begin
               if ((n == 8'd0) || (15'(n) > c_rem)) begin
                  fin     = 1'b1;
                  verdict = VERDICT_BAD_RUN;
               end else begin
                  rem_in = c_rem - 15'(n);
                  if (run) begin
                     phase_in = PH_RUNVAL;
                  end else begin
                     skip_in  = n;
                     phase_in = PH_LIT;
                  end
               end
            end
            PH_RUNVAL: begin
               chunk = 1'b1;
            end
            PH_LIT: begin
               skip_in = skip_dec;
               chunk   = (skip_dec == 8'd0);
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         if (chunk) begin
            if (c_rem != '0) begin
               phase_in = PH_CODE;
            end else if (c_chi == 2'd3) begin
               row_in = row_inc;
               if (row_inc >= c_hgt) begin
                  fin     = 1'b1;
                  verdict = VERDICT_OK;
                  len     = c_off + 32'd1;
               end else begin
                  phase_in = PH_M0;
               end
            end else begin
               chi_in   = c_chi + 2'd1;
               rem_in   = c_wid;
               phase_in = PH_CODE;
            end
         end

         case (phase_in)
            PH_M0:   need = 33'd4;
            PH_M1:   need = 33'd3;
            PH_WHI:  need = 33'd2;
            PH_LIT:  need = 33'(skip_in);
            default: need = 33'd1;
         endcase
         bound = {1'b0, lim_in};
         if ((phase_in <= PH_NL) && (bound > 33'(HEADER_WINDOW))) begin
            bound = 33'(HEADER_WINDOW);
         end
         nval_nx = over_in ? '0 : acc_in;

         if (!fin) begin
            if ({1'b0, c_off} + need >= bound) begin
               fin = 1'b1;
               if ((phase_in == PH_FIND_Y) || (phase_in == PH_HEIGHT) ||
                   (phase_in == PH_FIND_X)) begin
                  verdict = VERDICT_NO_DIMS;
               end else if (phase_in == PH_WIDTH) begin
                  wid_in  = nval_nx;
                  verdict = ((hgt_in != '0) && (nval_nx != '0)) ? VERDICT_TRUNC
                                                                : VERDICT_DIM_RANGE;
               end else begin
                  verdict = VERDICT_TRUNC;
               end
            end else begin
               off_in = c_off + 32'd1;
            end
         end
      end

      if (fin) begin
         phase_in = PH_IDLE;
      end

      result_fire = commit && fin;
      result.verdict      = verdict;
      result.total_length = len;
      result.image_height = hgt_in;
      result.image_width  = wid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tm_ff    <= '0;
         acc_ff   <= '0;
         over_ff  <= 1'b0;
         hgt_ff   <= '0;
         wid_ff   <= '0;
         row_ff   <= '0;
         chi_ff   <= '0;
         rem_ff   <= '0;
         skip_ff  <= '0;
         off_ff   <= '0;
         lim_ff   <= '0;
      end else if (commit) begin
         phase_ff <= phase_in;
         tm_ff    <= tm_in;
         acc_ff   <= acc_in;
         over_ff  <= over_in;
         hgt_ff   <= hgt_in;
         wid_ff   <= wid_in;
         row_ff   <= row_in;
         chi_ff   <= chi_in;
         rem_ff   <= rem_in;
         skip_ff  <= skip_in;
         off_ff   <= off_in;
         lim_ff   <= lim_in;
      end
   end

endmodule

>>> src/rgbe_image_extent_scanner.sv
// Radiance RGBE image extent scanner.
//
// Input channel (req_*): one byte of a candidate picture per word. A word with
// req_start_flag set opens a new candidate and samples req_span_limit; a start
// in the middle of a candidate drops the old one without a result.
// Result channel (rsp_*): at most one word per candidate, carrying the verdict,
// the total length (ok only), and the parsed height and width.
//
// A byte that is taken lands in the input register and is parsed from there
// when no result waits on the receiver; any result is registered for the result
// channel. Throughput is one byte per cycle unless the receiver stalls, set by
// the single parse stage that updates the header and run-length counters.
//
// When the receiver stalls with a result pending, an empty input register still
// takes one more byte; further bytes wait until the result is taken.
// Reset returns the parser to idle; bytes without a start are then ignored.
module rgbe_image_extent_scanner #(
   parameter int HEADER_WINDOW = 4096,
   parameter int MAX_DIM       = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_start_flag,
   input  logic [7:0]  req_byte_value,
   input  logic [31:0] req_span_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_verdict,
   output logic [31:0] rsp_total_length,
   output logic [14:0] rsp_image_height,
   output logic [14:0] rsp_image_width
);
   import rgbe_scan_pkg::*;

   logic       in_vld_ff, in_vld_in;
   item_type   in_item_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_item_ff;
   logic       step;
   logic       res_fire;
   result_type res;

   assign step      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || step;

   always_comb begin
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end

      if (res_fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   rgbe_scan_core #(
      .HEADER_WINDOW (HEADER_WINDOW),
      .MAX_DIM       (MAX_DIM)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (in_item_ff),
      .result_fire (res_fire),
      .result      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.start_flag <= req_start_flag;
         in_item_ff.byte_value <= req_byte_value;
         in_item_ff.span_limit <= req_span_limit;
      end
      if (res_fire) begin
         rsp_item_ff <= res;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_verdict      = rsp_item_ff.verdict;
   assign rsp_total_length = rsp_item_ff.total_length;
   assign rsp_image_height = rsp_item_ff.image_height;
   assign rsp_image_width  = rsp_item_ff.image_width;

endmodule
